[design/htb_pkg.sv]
`timescale 1ns / 1ps
// htb_pkg: sizes, command and result types, status codes and state codes
// shared by the Huffman tree builder. No dependencies.
package htb_pkg;

    localparam int MAX_LEAVES  = 32;
    localparam int WEIGHT_BITS = 16;
    localparam int NODE_SLOTS  = 2 * MAX_LEAVES;

    // Field widths of the transactions
    localparam int LEAF_W = 16;
    localparam int NODE_W = 21;
    localparam int IDX_W  = 6;
    localparam int STAT_W = 2;

    localparam int CNT_W  = $clog2(MAX_LEAVES + 1);
    localparam int LINK_W = 2 * IDX_W;

    // command queue between front and back
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    typedef enum logic [STAT_W-1:0] {
        BS_OK      = 2'd0,
        BS_TOO_FEW = 2'd1,
        BS_EXCESS  = 2'd2
    } t_build_status;

    // one command per accepted leaf transaction
    typedef struct packed {
        logic              store;   // write weight at addr
        logic              build;   // last leaf of the run: start the build
        logic              excess;  // a leaf was dropped in this run
        logic [IDX_W-1:0]  addr;    // leaf node number
        logic [CNT_W-1:0]  count;   // leaves held after this one
        logic [NODE_W-1:0] weight;
    } t_cmd;

    typedef struct packed {
        logic [IDX_W-1:0]  node_index;
        logic [NODE_W-1:0] node_weight;
        logic [IDX_W-1:0]  parent_index;
        logic [IDX_W-1:0]  left_index;
        logic [IDX_W-1:0]  right_index;
        t_build_status     build_status;
        logic              run_end;
    } t_node_res;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_SCAN     = 8'b0000_0010,
        ST_SCAN_END = 8'b0000_0100,
        ST_MERGE_A  = 8'b0000_1000,
        ST_MERGE_B  = 8'b0001_0000,
        ST_OUT_RD   = 8'b0010_0000,
        ST_OUT_LD   = 8'b0100_0000,
        ST_ERR      = 8'b1000_0000
    } t_back_state;

endpackage

[design/htb_if.sv]
`timescale 1ns / 1ps
// htb_if: valid/ready channel interfaces for leaf input and node output.
// Depends on htb_pkg.
interface htb_leaf_if import htb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [LEAF_W-1:0] leaf_weight;
    logic              final_leaf;

    modport source (output valid, output leaf_weight, output final_leaf, input ready);
    modport sink   (input valid, input leaf_weight, input final_leaf, output ready);
endinterface

interface htb_node_if import htb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  node_index;
    logic [NODE_W-1:0] node_weight;
    logic [IDX_W-1:0]  parent_index;
    logic [IDX_W-1:0]  left_index;
    logic [IDX_W-1:0]  right_index;
    logic [STAT_W-1:0] build_status;
    logic              run_end;

    modport source (output valid, output node_index, output node_weight,
                    output parent_index, output left_index, output right_index,
                    output build_status, output run_end, input ready);
    modport sink   (input valid, input node_index, input node_weight,
                    input parent_index, input left_index, input right_index,
                    input build_status, input run_end, output ready);
endinterface

[design/htb_ram.sv]
`timescale 1ns / 1ps
// htb_ram: generic one-write, one-read RAM with registered read data.
// No dependencies.
module htb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/htb_front.sv]
`timescale 1ns / 1ps
// htb_front: accepts leaf transactions, numbers them, drops excess leaves
// and turns each into a command for the queue. Depends on htb_pkg, htb_if.
module htb_front import htb_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    htb_leaf_if.sink      i_leaf,
    input  logic          i_full,
    output logic          o_push,
    output t_cmd          o_cmd
);

    logic [CNT_W-1:0] r_leaf_count, n_leaf_count;
    logic             r_excess, n_excess;
    logic             accept;
    logic             store;

    always_comb begin
        i_leaf.ready = !i_full;
        accept       = i_leaf.valid && !i_full;
        store        = r_leaf_count < CNT_W'(MAX_LEAVES);

        o_cmd.store  = store;
        o_cmd.build  = i_leaf.final_leaf;
        o_cmd.excess = r_excess || !store;
        o_cmd.addr   = IDX_W'(r_leaf_count) + IDX_W'(1);
        o_cmd.count  = store ? r_leaf_count + CNT_W'(1) : r_leaf_count;
        o_cmd.weight = NODE_W'(i_leaf.leaf_weight[WEIGHT_BITS-1:0]);
        o_push       = accept;

        n_leaf_count = r_leaf_count;
        n_excess     = r_excess;
        if (accept) begin
            if (i_leaf.final_leaf) begin
                n_leaf_count = '0;
                n_excess     = 1'b0;
            end else begin
                n_leaf_count = o_cmd.count;
                n_excess     = o_cmd.excess;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leaf_count <= '0;
            r_excess     <= 1'b0;
        end else begin
            r_leaf_count <= n_leaf_count;
            r_excess     <= n_excess;
        end
    end

endmodule

[design/htb_cmd_fifo.sv]
`timescale 1ns / 1ps
// htb_cmd_fifo: short command queue between front and back.
// Depends on htb_pkg.
module htb_cmd_fifo import htb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CMD_CNT_W-1:0] r_count, n_count;
    logic                 do_push, do_pop;

    always_comb begin
        o_full   = r_count == CMD_CNT_W'(CMD_DEPTH);
        o_empty  = r_count == '0;
        o_cmd    = r_mem[r_rd_ptr];
        do_push  = i_push && !o_full;
        do_pop   = i_pop && !o_empty;
        n_wr_ptr = do_push ? r_wr_ptr + CMD_PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + CMD_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CMD_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CMD_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[design/htb_back.sv]
`timescale 1ns / 1ps
// htb_back: stores leaf weights, runs the merge scans and streams out the
// node table. Depends on htb_pkg, htb_if, htb_ram.
module htb_back import htb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    htb_node_if.source o_node
);

    t_back_state r_state, n_state;
    logic        r_ovalid, n_ovalid;
    t_node_res   r_out, n_out;

    logic [CNT_W-1:0]      r_n, n_n;
    logic [IDX_W-1:0]      r_m, n_m;       // root node number
    logic [IDX_W-1:0]      r_node, n_node; // node being built
    logic [IDX_W-1:0]      r_addr, n_addr; // scan / output address
    t_build_status         r_status, n_status;
    logic [NODE_SLOTS-1:0] r_has_parent, n_has_parent;

    // scan pipeline: read issued last cycle
    logic             r_rd_valid;
    logic             r_rd_free;
    logic [IDX_W-1:0] r_rd_idx;

    // two least parentless nodes so far
    logic [IDX_W-1:0]  r_a, n_a, r_b, n_b;
    logic [NODE_W-1:0] r_wa, n_wa, r_wb, n_wb;
    logic              r_have_a, n_have_a, r_have_b, n_have_b;

    logic              w_we, p_we, l_we;
    logic [IDX_W-1:0]  w_waddr, p_waddr;
    logic [NODE_W-1:0] w_wdata, w_rdata;
    logic [IDX_W-1:0]  p_rdata;
    logic [LINK_W-1:0] l_rdata;

    htb_ram #(.WIDTH(NODE_W), .DEPTH(NODE_SLOTS)) u_weight_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_addr),
        .o_rdata(w_rdata)
    );

    htb_ram #(.WIDTH(IDX_W), .DEPTH(NODE_SLOTS)) u_parent_ram (
        .i_clk  (i_clk),
        .i_we   (p_we),
        .i_waddr(p_waddr),
        .i_wdata(r_node),
        .i_raddr(r_addr),
        .o_rdata(p_rdata)
    );

    htb_ram #(.WIDTH(LINK_W), .DEPTH(NODE_SLOTS)) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (l_we),
        .i_waddr(r_node),
        .i_wdata({r_a, r_b}),
        .i_raddr(r_addr),
        .o_rdata(l_rdata)
    );

    always_comb begin
        o_pop   = (r_state == ST_IDLE) && !i_empty;
        w_we    = (o_pop && i_cmd.store) || (r_state == ST_MERGE_A);
        w_waddr = (r_state == ST_MERGE_A) ? r_node : i_cmd.addr;
        w_wdata = (r_state == ST_MERGE_A) ? r_wa + r_wb : i_cmd.weight;
        p_we    = (r_state == ST_MERGE_A) || (r_state == ST_MERGE_B);
        p_waddr = (r_state == ST_MERGE_A) ? r_a : r_b;
        l_we    = r_state == ST_MERGE_A;
    end

    always_comb begin
        n_state      = r_state;
        n_ovalid     = r_ovalid;
        n_out        = r_out;
        n_n          = r_n;
        n_m          = r_m;
        n_node       = r_node;
        n_addr       = r_addr;
        n_status     = r_status;
        n_has_parent = r_has_parent;
        n_a          = r_a;
        n_b          = r_b;
        n_wa         = r_wa;
        n_wb         = r_wb;
        n_have_a     = r_have_a;
        n_have_b     = r_have_b;

        if (r_ovalid && o_node.ready) begin
            n_ovalid = 1'b0;
        end

        // running two-minimum, lower node number wins ties
        if (r_rd_valid && r_rd_free) begin
            if (!r_have_a || w_rdata < r_wa) begin
                n_b      = r_a;
                n_wb     = r_wa;
                n_have_b = r_have_a;
                n_a      = r_rd_idx;
                n_wa     = w_rdata;
                n_have_a = 1'b1;
            end else if (!r_have_b || w_rdata < r_wb) begin
                n_b      = r_rd_idx;
                n_wb     = w_rdata;
                n_have_b = 1'b1;
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty && i_cmd.build) begin
                    if (i_cmd.count < CNT_W'(2)) begin
                        n_state = ST_ERR;
                    end else begin
                        n_n          = i_cmd.count;
                        n_m          = IDX_W'(2 * i_cmd.count - 1);
                        n_node       = IDX_W'(i_cmd.count) + IDX_W'(1);
                        n_status     = i_cmd.excess ? BS_EXCESS : BS_OK;
                        n_addr       = IDX_W'(1);
                        n_has_parent = '0;
                        n_have_a     = 1'b0;
                        n_have_b     = 1'b0;
                        n_state      = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_addr == r_node - IDX_W'(1)) begin
                    n_state = ST_SCAN_END;
                end else begin
                    n_addr = r_addr + IDX_W'(1);
                end
            end
            ST_SCAN_END: begin
                n_state = ST_MERGE_A;
            end
            ST_MERGE_A: begin
                n_has_parent[r_a] = 1'b1;
                n_has_parent[r_b] = 1'b1;
                n_state           = ST_MERGE_B;
            end
            ST_MERGE_B: begin
                n_addr = IDX_W'(1);
                if (r_node == r_m) begin
                    n_state = ST_OUT_RD;
                end else begin
                    n_node   = r_node + IDX_W'(1);
                    n_have_a = 1'b0;
                    n_have_b = 1'b0;
                    n_state  = ST_SCAN;
                end
            end
            ST_OUT_RD: begin
                // read issued at r_addr; only when the output slot frees up
                if (!r_ovalid || o_node.ready) begin
                    n_state = ST_OUT_LD;
                end
            end
            ST_OUT_LD: begin
                n_ovalid           = 1'b1;
                n_out.node_index   = r_addr;
                n_out.node_weight  = w_rdata;
                n_out.parent_index = (r_addr == r_m) ? '0 : p_rdata;
                n_out.left_index   = (r_addr <= IDX_W'(r_n)) ? '0 : l_rdata[LINK_W-1:IDX_W];
                n_out.right_index  = (r_addr <= IDX_W'(r_n)) ? '0 : l_rdata[IDX_W-1:0];
                n_out.build_status = r_status;
                n_out.run_end      = r_addr == r_m;
                if (r_addr == r_m) begin
                    n_state = ST_IDLE;
                end else begin
                    n_addr  = r_addr + IDX_W'(1);
                    n_state = ST_OUT_RD;
                end
            end
            ST_ERR: begin
                if (!r_ovalid || o_node.ready) begin
                    n_ovalid           = 1'b1;
                    n_out.node_index   = '0;
                    n_out.node_weight  = '0;
                    n_out.parent_index = '0;
                    n_out.left_index   = '0;
                    n_out.right_index  = '0;
                    n_out.build_status = BS_TOO_FEW;
                    n_out.run_end      = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out        <= n_out;
        r_n          <= n_n;
        r_m          <= n_m;
        r_node       <= n_node;
        r_addr       <= n_addr;
        r_status     <= n_status;
        r_has_parent <= n_has_parent;
        r_a          <= n_a;
        r_b          <= n_b;
        r_wa         <= n_wa;
        r_wb         <= n_wb;
        r_have_a     <= n_have_a;
        r_have_b     <= n_have_b;
        r_rd_valid   <= r_state == ST_SCAN;
        r_rd_idx     <= r_addr;
        r_rd_free    <= !r_has_parent[r_addr];
    end

    assign o_node.valid        = r_ovalid;
    assign o_node.node_index   = r_out.node_index;
    assign o_node.node_weight  = r_out.node_weight;
    assign o_node.parent_index = r_out.parent_index;
    assign o_node.left_index   = r_out.left_index;
    assign o_node.right_index  = r_out.right_index;
    assign o_node.build_status = r_out.build_status;
    assign o_node.run_end      = r_out.run_end;

    a_out_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT_LD) |-> !r_ovalid)
        else $error("output register loaded while still occupied");

    a_merge_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MERGE_A) |-> (r_have_a && r_have_b && r_a != r_b
                                     && r_a < r_node && r_b < r_node))
        else $error("merge without two distinct parentless children");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_addr != '0 && r_addr < r_node))
        else $error("scan address outside built nodes");

endmodule

[design/huffman_tree_builder.sv]
`timescale 1ns / 1ps
// huffman_tree_builder: top level, front + command queue + back.
// Depends on htb_pkg, htb_if, htb_front, htb_cmd_fifo, htb_back.

// Leaf weights enter one per transaction on i_leaf and are numbered 1..n;
// the transaction with final_leaf set is itself a leaf and starts the build.
// Up to 32 leaves are kept per run, later ones are dropped and the run's
// results carry build_status 2. After the build the block streams all 2n-1
// node entries on o_node in node order, run_end marking the root; a run of
// fewer than two leaves yields a single result with status 1 and run_end
// set, all other fields zero. The front takes a leaf every cycle while the
// 4-entry command queue has room; the back pops commands only while idle.
// Each merge of a build scans nodes 1..i-1 (i the new node) through the
// single read port of the weight RAM, one node per cycle, waits in
// ST_SCAN_END for the last read to land, then writes the new node in
// ST_MERGE_A and ST_MERGE_B. Output then reads each node (ST_OUT_RD) and
// loads the output register (ST_OUT_LD), waiting while the sink holds off
// ready. New leaves are accepted into the queue during a build and wait
// there until the back returns to idle.
module huffman_tree_builder import htb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    htb_leaf_if.sink   i_leaf,
    htb_node_if.source o_node
);

    // front -> queue
    logic push;
    logic full;
    t_cmd push_cmd;

    // queue -> back
    logic pop;
    logic empty;
    t_cmd head_cmd;

    // front numbers leaves and flags drops/overflow per transaction
    htb_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_leaf (i_leaf),
        .i_full (full),
        .o_push (push),
        .o_cmd  (push_cmd)
    );

    // decouples leaf intake from the long build scan
    htb_cmd_fifo u_cmd_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .o_full (full),
        .i_pop  (pop),
        .o_cmd  (head_cmd),
        .o_empty(empty)
    );

    // back owns the node RAMs, the merge sequencer and the output register
    htb_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(empty),
        .i_cmd  (head_cmd),
        .o_pop  (pop),
        .o_node (o_node)
    );

endmodule

[dv/huffman_tree_builder_tb.sv]
`timescale 1ns / 1ps
// huffman_tree_builder_tb: self-checking testbench for the Huffman tree builder.
// Depends on htb_pkg, htb_if and the huffman_tree_builder RTL.
module huffman_tree_builder_tb;
    import htb_pkg::*;

    // Weight mixes used when making up a run of leaves
    typedef enum int {
        WT_ANY,     // full 16-bit range
        WT_TIES,    // tiny range, lots of equal weights
        WT_EXTREME  // only 0 and all-ones
    } t_wt_mix;

    localparam logic [NODE_W-1:0] WMASK = NODE_W'((1 << WEIGHT_BITS) - 1);

    logic i_clk;
    logic i_rst_n;

    htb_leaf_if leaf_ch ();
    htb_node_if node_ch ();

    huffman_tree_builder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_leaf  (leaf_ch),
        .o_node  (node_ch)
    );

    always #5 i_clk = ~i_clk;

    // Random idling, in percent: sender gaps and receiver stalls
    int idle_pct  = 0;
    int stall_pct = 0;
    int fail_count = 0;

    // ---------------------------------------------------------------------
    // Tree predictor: its own copy of the run state and node tables.
    // ---------------------------------------------------------------------
    int                stored_leaves = 0;
    bit                dropped_leaf  = 1'b0;
    logic [NODE_W-1:0] wt_tab  [NODE_SLOTS];
    int                par_tab [NODE_SLOTS];
    int                lft_tab [NODE_SLOTS];
    int                rgt_tab [NODE_SLOTS];

    // Node entries still owed by the block, oldest first
    t_node_res pending_nodes[$];

    // Lightest parentless node among 1..last, skipping one; lower number wins ties
    function automatic int least_free(int last, int skip);
        int best = 0;
        for (int k = 1; k <= last; k++) begin
            if (par_tab[k] != 0 || k == skip)
                continue;
            if (best == 0 || wt_tab[k] < wt_tab[best])
                best = k;
        end
        return best;
    endfunction

    // Account for one accepted leaf; a final leaf builds the tree and
    // queues every node entry (or the single too-few entry).
    function automatic void take_leaf(logic [LEAF_W-1:0] w, logic fin);
        int            n;
        int            m;
        int            a;
        int            b;
        t_build_status st;
        t_node_res     r;
        if (stored_leaves < MAX_LEAVES) begin
            stored_leaves++;
            wt_tab[stored_leaves] = NODE_W'(w) & WMASK;
        end else begin
            dropped_leaf = 1'b1;
        end
        if (!fin)
            return;

        n  = stored_leaves;
        st = dropped_leaf ? BS_EXCESS : BS_OK;
        stored_leaves = 0;
        dropped_leaf  = 1'b0;

        if (n < 2) begin
            r = '0;
            r.build_status = BS_TOO_FEW;
            r.run_end      = 1'b1;
            pending_nodes.push_back(r);
            return;
        end

        m = 2 * n - 1;
        for (int i = 1; i <= m; i++) begin
            par_tab[i] = 0;
            lft_tab[i] = 0;
            rgt_tab[i] = 0;
        end
        // each merge: left = lightest, right = lightest of the rest
        for (int i = n + 1; i <= m; i++) begin
            a = least_free(i - 1, 0);
            b = least_free(i - 1, a);
            par_tab[a] = i;
            par_tab[b] = i;
            wt_tab[i]  = wt_tab[a] + wt_tab[b];
            lft_tab[i] = a;
            rgt_tab[i] = b;
        end
        for (int i = 1; i <= m; i++) begin
            r.node_index   = IDX_W'(i);
            r.node_weight  = wt_tab[i];
            r.parent_index = IDX_W'(par_tab[i]);
            r.left_index   = IDX_W'(lft_tab[i]);
            r.right_index  = IDX_W'(rgt_tab[i]);
            r.build_status = st;
            r.run_end      = (i == m);
            pending_nodes.push_back(r);
        end
    endfunction

    function automatic string fmt_node(t_node_res r);
        return $sformatf("idx=%0d wt=%0d par=%0d l=%0d r=%0d st=%0d end=%0b",
                         r.node_index, r.node_weight, r.parent_index, r.left_index,
                         r.right_index, r.build_status, r.run_end);
    endfunction

    // ---------------------------------------------------------------------
    // Node receiver: checks each accepted transaction against the oldest
    // expectation, then picks ready for the next cycle.
    // ---------------------------------------------------------------------
    function automatic void check_node();
        t_node_res got;
        t_node_res want;
        got.node_index   = node_ch.node_index;
        got.node_weight  = node_ch.node_weight;
        got.parent_index = node_ch.parent_index;
        got.left_index   = node_ch.left_index;
        got.right_index  = node_ch.right_index;
        got.build_status = t_build_status'(node_ch.build_status);
        got.run_end      = node_ch.run_end;
        if (pending_nodes.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: node result with nothing expected: %s", $realtime,
                         fmt_node(got));
        end else begin
            want = pending_nodes.pop_front();
            if (got !== want) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: node mismatch\n  expected %s\n  actual   %s",
                             $realtime, fmt_node(want), fmt_node(got));
            end
        end
    endfunction

    always @(posedge i_clk) begin
        // ready is sampled before this edge's update, so it is what the DUT saw
        if (i_rst_n && node_ch.valid && node_ch.ready)
            check_node();
        node_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // ---------------------------------------------------------------------
    // Leaf sender
    // ---------------------------------------------------------------------
    // Drives one leaf and returns at the edge where it was taken. valid is
    // left high so back-to-back leaves never see a low/high pair in one step.
    task automatic send_leaf(input logic [LEAF_W-1:0] w, input logic fin);
        while ($urandom_range(99) < idle_pct) begin
            leaf_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        leaf_ch.valid       <= 1'b1;
        leaf_ch.leaf_weight <= w;
        leaf_ch.final_leaf  <= fin;
        do
            @(posedge i_clk);
        while (!leaf_ch.ready);
        take_leaf(w, fin);
    endtask

    function automatic logic [LEAF_W-1:0] pick_weight(t_wt_mix mix);
        case (mix)
            WT_TIES:    return LEAF_W'($urandom_range(3));
            WT_EXTREME: return $urandom_range(1) ? '1 : '0;
            default:    return LEAF_W'($urandom_range(65535));
        endcase
    endfunction

    // One run of n leaves, the last one marked final
    task automatic send_run(input int n, input t_wt_mix mix);
        for (int i = 1; i <= n; i++)
            send_leaf(pick_weight(mix), i == n);
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------
    // Short runs: weight extremes, too-few runs, tie breaking by node number
    task automatic test_short_runs();
        send_leaf(16'h0000, 1'b0);
        send_leaf(16'hFFFF, 1'b1);
        // single leaf: too-few result
        send_leaf(16'hFFFF, 1'b1);
        // all equal: lower node number must win every tie
        repeat (3) send_leaf(16'd7, 1'b0);
        send_leaf(16'd7, 1'b1);
        // all zero
        send_leaf(16'd0, 1'b0);
        send_leaf(16'd0, 1'b0);
        send_leaf(16'd0, 1'b1);
        // mixed ties where merged nodes tie with leaves
        send_leaf(16'd5, 1'b0);
        send_leaf(16'd1, 1'b0);
        send_leaf(16'd1, 1'b0);
        send_leaf(16'd5, 1'b0);
        send_leaf(16'd2, 1'b1);
        send_leaf(16'h0000, 1'b1);
        send_leaf(16'hAAAA, 1'b0);
        send_leaf(16'h5555, 1'b1);
    endtask

    // Full run of 32 max-weight leaves (root hits the widest weight), then
    // an overfull run whose final leaf itself gets dropped, then a normal
    // run to see the excess flag clear.
    task automatic test_capacity();
        repeat (MAX_LEAVES - 1) send_leaf(16'hFFFF, 1'b0);
        send_leaf(16'hFFFF, 1'b1);
        send_run(MAX_LEAVES + 2, WT_ANY);
        send_run(3, WT_ANY);
    endtask

    // Random runs under four handshake pressure settings
    task automatic test_random_runs();
        int      sent;
        int      n;
        int      pick;
        t_wt_mix mix;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 61; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 29; stall_pct = 29; end
            endcase
            sent = 0;
            while (sent < 28) begin
                pick = $urandom_range(99);
                // mostly short runs; a few too-few, full and overfull runs
                if (pick < 70)      n = $urandom_range(8, 2);
                else if (pick < 82) n = $urandom_range(31, 9);
                else if (pick < 90) n = 1;
                else if (pick < 95) n = MAX_LEAVES;
                else                n = $urandom_range(MAX_LEAVES + 6, MAX_LEAVES + 1);
                pick = $urandom_range(9);
                mix  = (pick < 6) ? WT_ANY : (pick < 9) ? WT_TIES : WT_EXTREME;
                send_run(n, mix);
                sent += n;
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        leaf_ch.valid       = 1'b0;
        leaf_ch.leaf_weight = '0;
        leaf_ch.final_leaf  = 1'b0;
        node_ch.ready       = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_short_runs();
        test_capacity();
        test_random_runs();

        leaf_ch.valid <= 1'b0;
        while (pending_nodes.size() != 0)
            @(posedge i_clk);
        // let any stray extra result show up
        repeat (100) @(posedge i_clk);

        if (fail_count == 0 && pending_nodes.size() == 0)
            $display("huffman_tree_builder_tb passed");
        else
            $display("huffman_tree_builder_tb failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run (5 ms)
    initial begin
        #5000000;
        $display("huffman_tree_builder_tb failed");
        $finish;
    end

endmodule
